### hdl/clip_point_sorted_toggle_list_defines.svh
// Assertion macros for the clip point toggle list.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CLIP_POINT_SORTED_TOGGLE_LIST_DEFINES_SVH
`define CLIP_POINT_SORTED_TOGGLE_LIST_DEFINES_SVH

// same-cycle implication
`define CPST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cpst_pkg.sv
// Shared types and constants for the clip point toggle list.
// No dependencies.
`default_nettype none
package cpst_pkg;

  localparam int MAX_POINTS = 16;
  localparam int DUMP_LIMIT = 16;
  localparam int DUMP_CAP   = (MAX_POINTS < DUMP_LIMIT) ? MAX_POINTS : DUMP_LIMIT;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] OP_TOGGLE = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_REMOVED = 3'd1;
  localparam logic [2:0] KIND_FULL    = 3'd2;
  localparam logic [2:0] KIND_CLEARED = 3'd3;
  localparam logic [2:0] KIND_ENTRY   = 3'd4;
  localparam logic [2:0] KIND_EMPTY   = 3'd5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic [4:0]         points_held;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } entry_t;

  // broadcast to every cell: probe point and sort order
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               use_x;
    logic               asc;
  } cmp_bus_t;

  typedef enum logic [1:0] {
    C_HOLD,
    C_LOAD,
    C_LEFT,
    C_RIGHT
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_AXIS,
    ST_CMP,
    ST_APPLY,
    ST_ONE,
    ST_DUMP
  } st_t;

endpackage
`default_nettype wire

### hdl/clip_point_sorted_toggle_list.sv
// Top level of the clip point toggle list: control sequencer around a ring of cells.
// Depends on cpst_pkg, cpst_cell and clip_point_sorted_toggle_list_defines.svh.
`default_nettype none
`include "clip_point_sorted_toggle_list_defines.svh"
// Handles one item at a time; in_ready is high only while the block is idle. A toggle
// passes span, axis and compare, then shift/insert in the cell ring when the output is
// free; clear and an empty dump give one result when the output is free; the unused
// opcode is taken with no result. A dump rotates the whole ring of MAX_POINTS cells once,
// one cell per cycle unless an entry waits on the output, emitting up to 16 entries from
// cell 0. Results sit in an output register; the next item is taken while the last waits.
module clip_point_sorted_toggle_list (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cpst_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cpst_pkg::out_item_t      out_item
);
  import cpst_pkg::*;

  st_t                     st_r, st_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  cmp_bus_t                bus_r, bus_nxt;
  logic signed [32:0]      xs_r, xs_nxt;
  logic signed [32:0]      ys_r, ys_nxt;
  logic [MAX_POINTS-1:0]   eq_r, eq_nxt;
  logic [MAX_POINTS-1:0]   bt_r, bt_nxt;
  logic [2:0]              kind_r, kind_nxt;
  out_item_t               out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  entry_t                  ent [MAX_POINTS];
  cell_op_t                cop [MAX_POINTS];
  logic [MAX_POINTS-1:0]   eq_vec;
  logic [MAX_POINTS-1:0]   bt_vec;
  logic [MAX_POINTS-1:0]   lt_n;
  logic [MAX_POINTS-1:0]   bsel;
  logic [MAX_POINTS-1:0]   ins_incl;
  logic [MAX_POINTS-1:0]   ins_before;
  logic [MAX_POINTS-1:0]   rm_incl;
  logic [CNT_W-1:0]        emit_n;
  logic [IDX_W-1:0]        last_idx;
  entry_t                  last_ent;
  logic [32:0]             xa;
  logic [32:0]             ya;
  logic                    axis_x;
  logic signed [32:0]      span;
  logic                    out_free;
  logic                    accept;
  logic                    dump_step;
  logic                    dump_emit;
  logic                    apply_go;

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      localparam int L = (g == 0) ? MAX_POINTS - 1 : g - 1;
      localparam int R = (g == MAX_POINTS - 1) ? 0 : g + 1;
      cpst_cell u_cell (
        .clk      (clk),
        .op       (cop[g]),
        .bus      (bus_r),
        .left_in  (ent[L]),
        .right_in (ent[R]),
        .ent      (ent[g]),
        .eq       (eq_vec[g]),
        .beyond   (bt_vec[g])
      );
    end
  endgenerate

  assign out_free  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign emit_n    = (count_r < CNT_W'(DUMP_CAP)) ? count_r : CNT_W'(DUMP_CAP);
  assign dump_emit = CNT_W'(idx_r) < emit_n;
  assign dump_step = !dump_emit || out_free;
  assign apply_go  = out_free;
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign last_ent  = ent[last_idx];

  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      lt_n[j] = CNT_W'(j) < count_r;
    end
    bsel       = ((count_r >= CNT_W'(2)) ? bt_r : '0) | ~lt_n;
    ins_incl   = ~((bsel - MAX_POINTS'(1)) & ~bsel);
    ins_before = ins_incl << 1;
    rm_incl    = ~((eq_r - MAX_POINTS'(1)) & ~eq_r);
    xa         = (xs_r < 0) ? 33'(-xs_r) : 33'(xs_r);
    ya         = (ys_r < 0) ? 33'(-ys_r) : 33'(ys_r);
    axis_x     = xa > ya;
    span       = axis_x ? xs_r : ys_r;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_item.opcode == OP_TOGGLE) begin
            st_nxt = ST_SPAN;
          end else if (in_item.opcode == OP_CLEAR) begin
            st_nxt = ST_ONE;
          end else if (in_item.opcode == OP_DUMP) begin
            st_nxt = (count_r == '0) ? ST_ONE : ST_DUMP;
          end
        end
      end
      ST_SPAN:  st_nxt = ST_AXIS;
      ST_AXIS:  st_nxt = ST_CMP;
      ST_CMP:   st_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) st_nxt = ST_IDLE;
      ST_ONE:   if (out_free) st_nxt = ST_IDLE;
      ST_DUMP: begin
        if (dump_step && idx_r == IDX_W'(MAX_POINTS - 1)) st_nxt = ST_IDLE;
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    in_ready  = rst_n && (st_r == ST_IDLE);
    count_nxt = count_r;
    idx_nxt   = idx_r;
    bus_nxt   = bus_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    eq_nxt    = eq_r;
    bt_nxt    = bt_r;
    kind_nxt  = kind_r;
    out_nxt   = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    for (int j = 0; j < MAX_POINTS; j++) begin
      cop[j] = C_HOLD;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          bus_nxt.px = in_item.point_x;
          bus_nxt.py = in_item.point_y;
          idx_nxt    = '0;
          kind_nxt   = (in_item.opcode == OP_CLEAR) ? KIND_CLEARED : KIND_EMPTY;
          if (in_item.opcode == OP_CLEAR) count_nxt = '0;
        end
      end
      ST_SPAN: begin
        xs_nxt = $signed({last_ent.x[31], last_ent.x}) - $signed({ent[0].x[31], ent[0].x});
        ys_nxt = $signed({last_ent.y[31], last_ent.y}) - $signed({ent[0].y[31], ent[0].y});
      end
      ST_AXIS: begin
        bus_nxt.use_x = axis_x;
        bus_nxt.asc   = span > 0;
      end
      ST_CMP: begin
        eq_nxt = eq_vec & lt_n;
        bt_nxt = bt_vec & lt_n;
      end
      ST_APPLY: begin
        if (apply_go) begin
          out_valid_nxt = 1'b1;
          if (|eq_r) begin
            out_nxt.kind = KIND_REMOVED;
            count_nxt    = count_r - CNT_W'(1);
            for (int j = 0; j < MAX_POINTS; j++) begin
              if (rm_incl[j]) cop[j] = C_RIGHT;
            end
          end else if (count_r == CNT_W'(MAX_POINTS)) begin
            out_nxt.kind = KIND_FULL;
          end else begin
            out_nxt.kind = KIND_ADDED;
            count_nxt    = count_r + CNT_W'(1);
            for (int j = 0; j < MAX_POINTS; j++) begin
              if (ins_before[j]) cop[j] = C_LEFT;
              else if (ins_incl[j]) cop[j] = C_LOAD;
            end
          end
          out_nxt.entry_index = '0;
          out_nxt.entry_x     = bus_r.px;
          out_nxt.entry_y     = bus_r.py;
          out_nxt.points_held = 5'(count_nxt);
          out_nxt.last        = 1'b1;
        end
      end
      ST_ONE: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.kind        = kind_r;
          out_nxt.entry_index = '0;
          out_nxt.entry_x     = '0;
          out_nxt.entry_y     = '0;
          out_nxt.points_held = 5'(count_r);
          out_nxt.last        = 1'b1;
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          idx_nxt = idx_r + IDX_W'(1);
          for (int j = 0; j < MAX_POINTS; j++) begin
            cop[j] = C_RIGHT;
          end
          if (dump_emit) begin
            out_valid_nxt       = 1'b1;
            out_nxt.kind        = KIND_ENTRY;
            out_nxt.entry_index = 4'(idx_r);
            out_nxt.entry_x     = ent[0].x;
            out_nxt.entry_y     = ent[0].y;
            out_nxt.points_held = 5'(count_r);
            out_nxt.last        = (CNT_W'(idx_r) + CNT_W'(1)) == emit_n;
          end
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    bus_r  <= bus_nxt;
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    eq_r   <= eq_nxt;
    bt_r   <= bt_nxt;
    kind_r <= kind_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CPST_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(MAX_POINTS), "count above capacity")
  `CPST_ASSERT_NEXT(a_busy_after_accept, accept && in_item.opcode != OP_UNUSED, st_r != ST_IDLE, "no work after accept")
  `CPST_ASSERT_NEXT(a_add_grows, st_r == ST_APPLY && apply_go && !(|eq_r) && count_r != CNT_W'(MAX_POINTS), count_r == $past(count_r) + CNT_W'(1), "insert did not grow list")
  `CPST_ASSERT_NEXT(a_remove_shrinks, st_r == ST_APPLY && apply_go && (|eq_r), count_r == $past(count_r) - CNT_W'(1), "remove did not shrink list")
  `CPST_ASSERT_NOW(a_dump_emit_free, st_r == ST_DUMP && dump_emit && dump_step, out_free, "dump overwrote pending item")

endmodule
`default_nettype wire

### hdl/cpst_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares to the probe point.
// Depends on cpst_pkg.
`default_nettype none
module cpst_cell (
  input  wire logic               clk,
  input  wire cpst_pkg::cell_op_t op,
  input  wire cpst_pkg::cmp_bus_t bus,
  input  wire cpst_pkg::entry_t   left_in,
  input  wire cpst_pkg::entry_t   right_in,
  output cpst_pkg::entry_t        ent,
  output logic                    eq,
  output logic                    beyond
);
  import cpst_pkg::*;

  entry_t             ent_r;
  entry_t             ent_nxt;
  logic signed [31:0] v;
  logic signed [31:0] key;

  always_comb begin
    unique case (op)
      C_HOLD:  ent_nxt = ent_r;
      C_LOAD:  ent_nxt = '{x: bus.px, y: bus.py};
      C_LEFT:  ent_nxt = left_in;
      C_RIGHT: ent_nxt = right_in;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  always_comb begin
    v      = bus.use_x ? ent_r.x : ent_r.y;
    key    = bus.use_x ? bus.px : bus.py;
    eq     = (ent_r.x == bus.px) && (ent_r.y == bus.py);
    beyond = bus.asc ? (v > key) : (v < key);
  end

  assign ent = ent_r;

endmodule
`default_nettype wire
